>>> src/mntp_pkg.sv
// ----------------------------------------------------------------------------
// mntp_pkg
// Shared types, constants and the key frequency table of the MIDI note tone
// period controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mntp_pkg;

	localparam int CHANNELS_DEF    = 16;
	localparam int PERIOD_BITS_DEF = 24;

	localparam int NUM_W  = 24;
	localparam int TMO_W  = 16;
	localparam int TONE_W = 14;
	localparam int MS_W   = 32;
	localparam int CNT_W  = 5;

	localparam logic [NUM_W-1:0]  NUM_RST  = 24'd12000000;
	localparam logic [TMO_W-1:0]  TMO_RST  = 16'd2000;
	localparam logic [TONE_W-1:0] MIN_RST  = 14'd20;

	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

	typedef enum logic [1:0] {
		REG_NUMERATOR = 2'd0,
		REG_TIMEOUT   = 2'd1,
		REG_MIN_TONE  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_STATUS = 2'd1,
		PH_DATA1  = 2'd2,
		PH_DONE   = 2'd3
	} parse_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DIV,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic [NUM_W-1:0]  numerator;
		logic [TMO_W-1:0]  timeout;
		logic [TONE_W-1:0] min_tone;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic scan_step;
		logic decide;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic start_go;
		logic div_last;
		logic out_busy;
	} dp_sts_t;

	localparam logic [TONE_W-1:0] KEY_HZ [128] = '{
		14'd8,     14'd8,     14'd9,     14'd9,     14'd10,    14'd10,
		14'd11,    14'd12,    14'd12,    14'd13,    14'd14,    14'd15,
		14'd16,    14'd17,    14'd18,    14'd19,    14'd20,    14'd21,
		14'd23,    14'd24,    14'd25,    14'd27,    14'd29,    14'd30,
		14'd32,    14'd34,    14'd36,    14'd38,    14'd41,    14'd43,
		14'd46,    14'd48,    14'd51,    14'd55,    14'd58,    14'd61,
		14'd65,    14'd69,    14'd73,    14'd77,    14'd82,    14'd87,
		14'd92,    14'd97,    14'd103,   14'd110,   14'd116,   14'd123,
		14'd130,   14'd138,   14'd146,   14'd155,   14'd164,   14'd174,
		14'd184,   14'd195,   14'd207,   14'd220,   14'd233,   14'd246,
		14'd261,   14'd277,   14'd293,   14'd311,   14'd329,   14'd349,
		14'd369,   14'd391,   14'd415,   14'd440,   14'd466,   14'd493,
		14'd523,   14'd554,   14'd587,   14'd622,   14'd659,   14'd698,
		14'd739,   14'd783,   14'd830,   14'd880,   14'd932,   14'd987,
		14'd1046,  14'd1108,  14'd1174,  14'd1244,  14'd1318,  14'd1396,
		14'd1479,  14'd1567,  14'd1661,  14'd1760,  14'd1864,  14'd1975,
		14'd2093,  14'd2217,  14'd2349,  14'd2489,  14'd2637,  14'd2793,
		14'd2959,  14'd3135,  14'd3322,  14'd3520,  14'd3729,  14'd3951,
		14'd4186,  14'd4434,  14'd4698,  14'd4978,  14'd5274,  14'd5587,
		14'd5919,  14'd6271,  14'd6644,  14'd7040,  14'd7458,  14'd7902,
		14'd8372,  14'd8869,  14'd9397,  14'd9956,  14'd10548, 14'd11175,
		14'd11839, 14'd12543
	};

endpackage

`default_nettype wire

>>> src/mntp_cfg.sv
// ----------------------------------------------------------------------------
// mntp_cfg
// APB-style register file: period numerator, timeout and minimum tone.
// ----------------------------------------------------------------------------
`default_nettype none

module mntp_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output mntp_pkg::cfg_t     cfg
);
	import mntp_pkg::*;

	logic [NUM_W-1:0]  num_q;
	logic [TMO_W-1:0]  tmo_q;
	logic [TONE_W-1:0] min_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_RST;
			tmo_q <= TMO_RST;
			min_q <= MIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_NUMERATOR: num_q <= pwdata[NUM_W-1:0];
				REG_TIMEOUT:   tmo_q <= pwdata[TMO_W-1:0];
				REG_MIN_TONE:  min_q <= pwdata[TONE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_NUMERATOR: prdata = {{(32-NUM_W){1'b0}}, num_q};
			REG_TIMEOUT:   prdata = {{(32-TMO_W){1'b0}}, tmo_q};
			REG_MIN_TONE:  prdata = {{(32-TONE_W){1'b0}}, min_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg.numerator = num_q;
	assign cfg.timeout   = tmo_q;
	assign cfg.min_tone  = min_q;

endmodule

`default_nettype wire

>>> src/mntp_ctrl.sv
// ----------------------------------------------------------------------------
// mntp_ctrl
// Sequencer: take item, scan channel slots, decide, divide when a tone starts, deliver result.
// ----------------------------------------------------------------------------
`default_nettype none

module mntp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire mntp_pkg::dp_sts_t sts,
	output mntp_pkg::dp_cmd_t  cmd
);
	import mntp_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.start_go ? ST_DIV : ST_FINISH;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_take_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SCAN)
		else $error("accepted item did not start scan");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_busy)
		else $error("result loaded over a pending item");

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE && sts.start_go |=> state_q == ST_DIV)
		else $error("tone start did not enter division");

endmodule

`default_nettype wire

>>> src/mntp_dp.sv
// ----------------------------------------------------------------------------
// mntp_dp
// Datapath: MIDI parser, channel slots, max scan, serial divider, tone
// decision and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mntp_dp #(
	parameter int CHANNELS    = mntp_pkg::CHANNELS_DEF,
	parameter int PERIOD_BITS = mntp_pkg::PERIOD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire mntp_pkg::cfg_t               cfg,
	input  wire mntp_pkg::dp_cmd_t            cmd,
	output mntp_pkg::dp_sts_t                 sts,
	input  wire logic                         action,
	input  wire logic [7:0]                   midi_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              tone_enable,
	output logic [mntp_pkg::NUM_W-1:0]        tone_period,
	output logic                              counter_restart,
	output logic [mntp_pkg::TONE_W-1:0]       selected_tone
);
	import mntp_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [NUM_W-1:0] PMASK = (PERIOD_BITS >= NUM_W) ? {NUM_W{1'b1}} :
		NUM_W'((64'd1 << PERIOD_BITS) - 64'd1);

	parse_phase_t      phase_q;
	logic [7:0]        status_q;
	logic [7:0]        first_q;
	logic [TONE_W-1:0] slot_q [CHANNELS];
	logic [IDX_W-1:0]  idx_q;
	logic [TONE_W-1:0] max_q;
	logic [TONE_W-1:0] last_tone_q;
	logic [NUM_W-1:0]  period_q;
	logic              enabled_q;
	logic              restart_q;
	logic [MS_W-1:0]   ms_q;
	logic [MS_W-1:0]   start_q;
	logic [NUM_W-1:0]  dq_q;
	logic [TONE_W-1:0] rem_q;
	logic [TONE_W-1:0] dvs_q;
	logic [CNT_W-1:0]  dcnt_q;

	logic [3:0]        ch;
	logic              ch_ok;
	logic [TONE_W-1:0] slot_rd;
	logic              start_go;
	logic              stop_go;
	logic [MS_W-1:0]   elapsed;
	logic [TONE_W:0]   trial;
	logic              ge;
	logic [TONE_W-1:0] rem_d;
	logic [NUM_W-1:0]  dq_d;

	assign ch      = status_q[3:0];
	assign ch_ok   = {1'b0, ch} < 5'(CHANNELS);
	assign slot_rd = slot_q[idx_q];

	assign elapsed  = ms_q - start_q;
	assign start_go = (max_q > cfg.min_tone) && (max_q != last_tone_q);
	assign stop_go  = ((max_q < cfg.min_tone) && (max_q != last_tone_q)) ||
		(elapsed > {{(MS_W-TMO_W){1'b0}}, cfg.timeout});

	assign trial = {rem_q, dq_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign rem_d = ge ? TONE_W'(trial - {1'b0, dvs_q}) : trial[TONE_W-1:0];
	assign dq_d  = {dq_q[NUM_W-2:0], ge};

	// parser and channel slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			status_q <= 8'd0;
			first_q  <= 8'd0;
			ms_q     <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (cmd.take) begin
			if (action) begin
				ms_q <= ms_q + 1'b1;
			end else if (midi_byte[7]) begin
				status_q <= midi_byte;
				first_q  <= 8'd0;
				phase_q  <= PH_STATUS;
			end else if (phase_q == PH_STATUS) begin
				first_q <= midi_byte;
				phase_q <= PH_DATA1;
			end else if (phase_q == PH_DATA1) begin
				phase_q <= PH_DONE;
				if (ch_ok) begin
					if (status_q[7:4] == KIND_NOTE_ON) begin
						slot_q[ch[IDX_W-1:0]] <= KEY_HZ[first_q[6:0]];
					end else if (status_q[7:4] == KIND_NOTE_OFF) begin
						slot_q[ch[IDX_W-1:0]] <= '0;
					end
				end
			end
		end
	end

	// max scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			max_q <= '0;
		end else if (cmd.take) begin
			idx_q <= '0;
			max_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (slot_rd > max_q) begin
				max_q <= slot_rd;
			end
		end
	end

	// decision and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tone_q <= '0;
			period_q    <= '0;
			enabled_q   <= 1'b0;
			restart_q   <= 1'b0;
			start_q     <= '0;
			dcnt_q      <= '0;
		end else if (cmd.decide) begin
			dcnt_q <= '0;
			if (start_go) begin
				enabled_q   <= 1'b1;
				restart_q   <= 1'b1;
				last_tone_q <= max_q;
				start_q     <= ms_q;
			end else if (stop_go) begin
				enabled_q <= 1'b0;
				restart_q <= 1'b1;
			end else begin
				restart_q <= 1'b0;
			end
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (sts.div_last) begin
				period_q <= dq_d & PMASK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			dq_q  <= cfg.numerator;
			rem_q <= '0;
			dvs_q <= max_q;
		end else if (cmd.div_step) begin
			dq_q  <= dq_d;
			rem_q <= rem_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			tone_enable     <= enabled_q;
			tone_period     <= period_q;
			counter_restart <= restart_q;
			selected_tone   <= max_q;
		end
	end

	assign sts.scan_last = idx_q == IDX_W'(CHANNELS - 1);
	assign sts.start_go  = start_go;
	assign sts.div_last  = dcnt_q == CNT_W'(NUM_W - 1);
	assign sts.out_busy  = out_valid && !out_ready;

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("loaded item not presented");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> dvs_q != '0)
		else $error("division by zero tone");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> {1'b0, idx_q} < (IDX_W+1)'(CHANNELS))
		else $error("scan index out of range");

endmodule

`default_nettype wire

>>> src/midi_note_tone_period_controller.sv
// ----------------------------------------------------------------------------
// midi_note_tone_period_controller
// MIDI note to tone period controller.
//
// Input channel (in_valid/in_ready): one item is a received MIDI byte
// (action = 0) or a one-millisecond tick (action = 1). Note-on and note-off
// messages set or clear a channel slot; the highest slot frequency decides
// whether the tone timer starts, holds or stops.
// Output channel (out_valid/out_ready): exactly one item per input item with
// tone_enable, tone_period, counter_restart and selected_tone.
// Steps in order: accept, a scan over the channel slots, decide, then a
// radix-2 serial divider only when a new tone starts, and a load into the
// output register. One item is in work at a time: the next item is taken
// only after the last one has been loaded into the output register.
// A stalled receiver holds the result in the output register; the next item
// is taken and worked on, and waits in its last step until the held item
// leaves. Reset clears parser, slots, tone state, timers and both channels;
// registers return to 12000000, 2000 and 20.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_tone_period_controller #(
	parameter int CHANNELS    = mntp_pkg::CHANNELS_DEF,
	parameter int PERIOD_BITS = mntp_pkg::PERIOD_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [3:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    action,
	input  wire logic [7:0]              midi_byte,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         tone_enable,
	output logic [mntp_pkg::NUM_W-1:0]   tone_period,
	output logic                         counter_restart,
	output logic [mntp_pkg::TONE_W-1:0]  selected_tone
);
	import mntp_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	mntp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mntp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mntp_dp #(
		.CHANNELS    (CHANNELS),
		.PERIOD_BITS (PERIOD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.action          (action),
		.midi_byte       (midi_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tone_enable     (tone_enable),
		.tone_period     (tone_period),
		.counter_restart (counter_restart),
		.selected_tone   (selected_tone)
	);

endmodule

`default_nettype wire
